/* rtl/sld_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  localparam int BYTE_W        = 8;
  localparam int MAX_FRAME_DEF = 64;
  localparam int OUT_LIMIT     = 64;
  localparam int OCNT_W        = $clog2(OUT_LIMIT + 1);

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h55;
  localparam logic [BYTE_W-1:0] MIN_LEN    = 8'd3;

  localparam logic [2:0] REG_SYNC_ADDR = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_PROC,
    ST_ERD,
    ST_EOUT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
    logic              fend;
    logic              flush;
  } out_req_t;

  typedef struct packed {
    logic can_push;
    logic can_flush;
    logic hold_v;
  } out_stat_t;

endpackage

`default_nettype wire

/* rtl/sync_length_xor_deframer_top.sv */
// A byte that causes no result is written to the history memory and scanned, and scanned
// again as a sync byte when it is a rejected length byte. Every rescanned byte and every
// emitted frame byte is fetched by a registered read of the single history memory; a
// request with results ends with a flush. Its last result passes through the memory read
// register, the hold register and the output register, and waits while the output stalls.
// Synchronous active-low reset returns to the sync hunt with sync_value 0x55.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_xor_deframer_top #(
  parameter int MAX_FRAME = sld_pkg::MAX_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [7:0]  out_tdata,  // [7:0] out_byte
  output logic             out_tlast,
  output logic             out_tuser,  // [0] run_last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import sld_pkg::*;

  localparam int AW = $clog2(MAX_FRAME);

  logic [BYTE_W-1:0] sync_r, sync_nxt;
  logic              cfg_hit;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  out_req_t          oreq;
  out_stat_t         ostat;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr == REG_SYNC_ADDR);
  assign cfg_prdata = cfg_hit ? {24'd0, sync_r} : 32'd0;

  always_comb begin
    sync_nxt = sync_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      sync_nxt = cfg_pwdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RESET;
    end else begin
      sync_r <= sync_nxt;
    end
  end

  sld_hist_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .wr_en (mem_wr_en),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rd_en (mem_rd_en),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sld_ctrl #(
    .MAX_FRAME (MAX_FRAME),
    .AW        (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .sync_value (sync_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .wr_en      (mem_wr_en),
    .waddr      (mem_waddr),
    .wdata      (mem_wdata),
    .rd_en      (mem_rd_en),
    .raddr      (mem_raddr),
    .rdata      (mem_rdata),
    .req        (oreq),
    .stat       (ostat)
  );

  sld_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (oreq),
    .stat       (ostat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* rtl/sld_hist_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module sld_hist_mem #(
  parameter int AW = 6
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [sld_pkg::BYTE_W-1:0] wdata,
  input  wire logic                      rd_en,
  input  wire logic [AW-1:0]             raddr,
  output logic      [sld_pkg::BYTE_W-1:0] rdata
);
  import sld_pkg::*;

  localparam int DEPTH = 1 << AW;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[raddr];
    end
  end

  assign rdata = q_r;

endmodule

`default_nettype wire

/* rtl/sld_out.sv */
`timescale 1ns / 1ps
`default_nettype none

module sld_out (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire sld_pkg::out_req_t         req,
  output sld_pkg::out_stat_t             stat,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic      [sld_pkg::BYTE_W-1:0] out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser
);
  import sld_pkg::*;

  logic              hold_v_r, hold_v_nxt;
  logic [BYTE_W-1:0] hold_data_r, hold_data_nxt;
  logic              hold_end_r, hold_end_nxt;
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_end_r, out_end_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;

  assign out_free       = !out_v_r || out_tready;
  assign stat.can_push  = !hold_v_r || out_free;
  assign stat.can_flush = out_free;
  assign stat.hold_v    = hold_v_r;

  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_data_nxt = hold_data_r;
    hold_end_nxt  = hold_end_r;
    out_v_nxt     = out_v_r;
    out_data_nxt  = out_data_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    if (out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (req.push) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_data_nxt = hold_data_r;
        out_end_nxt  = hold_end_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt    = 1'b1;
      hold_data_nxt = req.data;
      hold_end_nxt  = req.fend;
    end else if (req.flush) begin
      out_v_nxt    = 1'b1;
      out_data_nxt = hold_data_r;
      out_end_nxt  = hold_end_r;
      out_last_nxt = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_data_r <= hold_data_nxt;
    hold_end_r  <= hold_end_nxt;
    out_data_r  <= out_data_nxt;
    out_end_r   <= out_end_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n) req.push |-> stat.can_push)
    else $error("Result pushed while the output stage is full.");
  assert property (@(posedge clk) disable iff (!rst_n) req.flush |-> (hold_v_r && out_free))
    else $error("Flush without a held result or a free output register.");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_v_r && !out_tready && !req.push && !req.flush) |=> out_v_r)
    else $error("Pending result lost without a transfer.");

endmodule

`default_nettype wire

/* rtl/sld_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sld_ctrl #(
  parameter int MAX_FRAME = sld_pkg::MAX_FRAME_DEF,
  parameter int AW        = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [sld_pkg::BYTE_W-1:0] sync_value,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [sld_pkg::BYTE_W-1:0] in_tdata,
  output logic                           wr_en,
  output logic      [AW-1:0]             waddr,
  output logic      [sld_pkg::BYTE_W-1:0] wdata,
  output logic                           rd_en,
  output logic      [AW-1:0]             raddr,
  input  wire logic [sld_pkg::BYTE_W-1:0] rdata,
  output sld_pkg::out_req_t              req,
  input  wire sld_pkg::out_stat_t        stat
);
  import sld_pkg::*;

  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_FRAME);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [AW-1:0]     sync_pos_r, sync_pos_nxt;
  logic [AW-1:0]     eptr_r, eptr_nxt;
  logic [BYTE_W-1:0] ecnt_r, ecnt_nxt;
  logic [BYTE_W-1:0] fill_r, fill_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              src_mem_r, src_mem_nxt;
  logic [OCNT_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] cur;
  logic              advance;
  logic              emit_done;

  assign cur = src_mem_r ? rdata : byte_r;

  always_comb begin
    state_nxt    = state_r;
    wptr_nxt     = wptr_r;
    rptr_nxt     = rptr_r;
    sync_pos_nxt = sync_pos_r;
    eptr_nxt     = eptr_r;
    ecnt_nxt     = ecnt_r;
    fill_nxt     = fill_r;
    len_nxt      = len_r;
    xor_nxt      = xor_r;
    in_frame_nxt = in_frame_r;
    byte_nxt     = byte_r;
    src_mem_nxt  = src_mem_r;
    cnt_nxt      = cnt_r;
    in_tready    = 1'b0;
    wr_en        = 1'b0;
    waddr        = wptr_r;
    wdata        = in_tdata;
    rd_en        = 1'b0;
    raddr        = rptr_r;
    req          = '0;
    req.data     = rdata;
    req.fend     = (ecnt_r == '0);
    advance      = 1'b0;
    emit_done    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          wr_en       = 1'b1;
          wptr_nxt    = wptr_r + AW'(1);
          byte_nxt    = in_tdata;
          src_mem_nxt = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = ST_PROC;
        end
      end
      ST_RD: begin
        rd_en       = 1'b1;
        src_mem_nxt = 1'b1;
        state_nxt   = ST_PROC;
      end
      ST_PROC: begin
        if (!in_frame_r) begin
          if (cur == sync_value) begin
            sync_pos_nxt = rptr_r;
            fill_nxt     = 8'd1;
            xor_nxt      = cur;
            in_frame_nxt = 1'b1;
          end
          rptr_nxt = rptr_r + AW'(1);
          advance  = 1'b1;
        end else if (fill_r == 8'd1) begin
          if (cur < MIN_LEN || cur > MAX_LEN) begin
            in_frame_nxt = 1'b0;
            fill_nxt     = '0;
          end else begin
            len_nxt  = cur;
            xor_nxt  = xor_r ^ cur;
            fill_nxt = 8'd2;
            rptr_nxt = rptr_r + AW'(1);
            advance  = 1'b1;
          end
        end else if ((fill_r + 8'd1) < len_r && fill_r < MAX_LEN) begin
          fill_nxt = fill_r + 8'd1;
          xor_nxt  = xor_r ^ cur;
          rptr_nxt = rptr_r + AW'(1);
          advance  = 1'b1;
        end else begin
          in_frame_nxt = 1'b0;
          fill_nxt     = '0;
          xor_nxt      = '0;
          if (cur == xor_r) begin
            eptr_nxt  = sync_pos_r;
            ecnt_nxt  = fill_r + 8'd1;
            rptr_nxt  = rptr_r + AW'(1);
            state_nxt = ST_ERD;
          end else begin
            rptr_nxt = sync_pos_r + AW'(1);
            advance  = 1'b1;
          end
        end
        if (advance) begin
          if (rptr_nxt != wptr_r) begin
            state_nxt = ST_RD;
          end else if (stat.hold_v) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ERD: begin
        rd_en     = 1'b1;
        raddr     = eptr_r;
        eptr_nxt  = eptr_r + AW'(1);
        ecnt_nxt  = ecnt_r - 8'd1;
        state_nxt = ST_EOUT;
      end
      ST_EOUT: begin
        if (cnt_r == OCNT_W'(OUT_LIMIT)) begin
          emit_done = 1'b1;
        end else if (stat.can_push) begin
          req.push  = 1'b1;
          cnt_nxt   = cnt_r + OCNT_W'(1);
          emit_done = 1'b1;
        end
        if (emit_done) begin
          if (ecnt_r != '0) begin
            state_nxt = ST_ERD;
          end else if (rptr_r != wptr_r) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!stat.hold_v) begin
          state_nxt = ST_IDLE;
        end else if (stat.can_flush) begin
          req.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      wptr_r     <= '0;
      rptr_r     <= '0;
      fill_r     <= '0;
      len_r      <= '0;
      xor_r      <= '0;
      in_frame_r <= 1'b0;
      ecnt_r     <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      wptr_r     <= wptr_nxt;
      rptr_r     <= rptr_nxt;
      fill_r     <= fill_nxt;
      len_r      <= len_nxt;
      xor_r      <= xor_nxt;
      in_frame_r <= in_frame_nxt;
      ecnt_r     <= ecnt_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sync_pos_r <= sync_pos_nxt;
    eptr_r     <= eptr_nxt;
    byte_r     <= byte_nxt;
    src_mem_r  <= src_mem_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_IDLE) |-> (rptr_r == wptr_r))
    else $error("Input taken while buffered bytes remain unscanned.");
  assert property (@(posedge clk) disable iff (!rst_n)
                   in_frame_r |-> (fill_r != '0 && fill_r <= MAX_LEN))
    else $error("Open frame with an impossible fill count.");
  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_ERD) |-> (ecnt_r != '0))
    else $error("Frame emission read past the frame end.");
  assert property (@(posedge clk) disable iff (!rst_n) (!in_frame_r) |-> (fill_r == '0))
    else $error("Fill count left behind after a frame closed.");

endmodule

`default_nettype wire
